// ===== sv/tlb_pkg.sv =====
// Shared types, constants and codes for the move-to-front TLB.
package tlb_pkg;

  // Built depth of the entry chain.
  localparam int TlbDepth = 16;

  // Field widths.
  localparam int PidW   = 16;
  localparam int PageW  = 12;
  localparam int FrameW = 12;
  localparam int ReqW   = 2;
  localparam int CfgW   = 5;

  // Register reset value for entries_in_use.
  localparam int CfgReset = 16;

  // Width wide enough for both the register and the built depth.
  localparam int DepthCntW = $clog2(TlbDepth + 1);
  localparam int UseW      = (DepthCntW > CfgW) ? DepthCntW : CfgW;

  // Request codes.
  typedef enum logic [ReqW-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_FLUSH  = 2'd3
  } req_t;

  // Per-cell update operation.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PREV,
    CELL_NEXT,
    CELL_LOAD,
    CELL_CLEAR
  } cell_op_t;

  // One TLB entry.
  typedef struct packed {
    logic              valid;
    logic [PidW-1:0]   pid;
    logic [PageW-1:0]  page;
    logic [FrameW-1:0] frame;
  } entry_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

endpackage

// ===== sv/tlb_cell.sv =====
// One TLB entry cell: holds an entry, compares it and takes from its neighbours.
module tlb_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  tlb_pkg::cell_op_t            op,
  input  tlb_pkg::entry_t              prev_entry,
  input  tlb_pkg::entry_t              next_entry,
  input  tlb_pkg::entry_t              load_entry,
  input  logic [tlb_pkg::PidW-1:0]     req_pid,
  input  logic [tlb_pkg::PageW-1:0]    req_page,
  output tlb_pkg::entry_t              entry,
  output logic                         match
);

  logic                         valid;
  logic [tlb_pkg::PidW-1:0]     pid;
  logic [tlb_pkg::PageW-1:0]    page;
  logic [tlb_pkg::FrameW-1:0]   frame;

  // Present the held entry to the neighbours.
  assign entry = {valid, pid, page, frame};

  // Compare the held entry against the request.
  assign match = valid && (pid == req_pid) && (page == req_page);

  // Valid bit: cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        tlb_pkg::CELL_PREV:  valid <= prev_entry.valid;
        tlb_pkg::CELL_NEXT:  valid <= next_entry.valid;
        tlb_pkg::CELL_LOAD:  valid <= load_entry.valid;
        tlb_pkg::CELL_CLEAR: valid <= 1'b0;
        default:             valid <= valid;
      endcase
    end
  end

  // Payload: no reset.
  always_ff @(posedge clk) begin
    case (op)
      tlb_pkg::CELL_PREV: begin
        pid   <= prev_entry.pid;
        page  <= prev_entry.page;
        frame <= prev_entry.frame;
      end
      tlb_pkg::CELL_NEXT: begin
        pid   <= next_entry.pid;
        page  <= next_entry.page;
        frame <= next_entry.frame;
      end
      tlb_pkg::CELL_LOAD: begin
        pid   <= load_entry.pid;
        page  <= load_entry.page;
        frame <= load_entry.frame;
      end
      default: begin
        pid   <= pid;
        page  <= page;
        frame <= frame;
      end
    endcase
  end

endmodule

// ===== sv/tlb_lru_move_to_front.sv =====
// Top level: fully associative TLB kept in recency order by a chain of entry cells.
//
//  channel   dir  handshake              payload
//  request   in   in_valid / in_stall    req_type, pid, page, frame
//  result    out  out_valid / out_stall  hit, frame_out
//  config    in   cfg_we                 cfg_data (entries_in_use)
//
// An item goes through capture, compare in every cell, then shift the chain.
// The compare is registered before the first-match pick and the shift.
// A new request is taken only once the previous item has finished its shift.
// rst is synchronous: all entries go invalid, entries_in_use returns to 16.
// A stalled result holds the shift stage until the output register frees.
module tlb_lru_move_to_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlb_pkg::ReqW-1:0]      req_type,
  input  logic [tlb_pkg::PidW-1:0]      pid,
  input  logic [tlb_pkg::PageW-1:0]     page,
  input  logic [tlb_pkg::FrameW-1:0]    frame,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [tlb_pkg::FrameW-1:0]    frame_out,
  input  logic                          cfg_we,
  input  logic [tlb_pkg::CfgW-1:0]      cfg_data
);

  localparam int N = tlb_pkg::TlbDepth;

  tlb_pkg::state_t            state;
  tlb_pkg::state_t            state_next;
  logic                       in_take;
  logic                       match_en;
  logic                       upd_go;

  logic [tlb_pkg::CfgW-1:0]   entries_in_use;
  logic [tlb_pkg::UseW-1:0]   cfg_ext;
  logic [tlb_pkg::UseW-1:0]   n_used;

  tlb_pkg::req_t              req_q;
  logic [tlb_pkg::PidW-1:0]   pid_q;
  logic [tlb_pkg::PageW-1:0]  page_q;
  logic [tlb_pkg::FrameW-1:0] frame_q;

  tlb_pkg::entry_t            cell_entry [N];
  tlb_pkg::cell_op_t          cell_op    [N];
  logic [N-1:0]               match_c;
  logic [N-1:0]               match_q;
  logic [N-1:0]               in_use;
  logic [N-1:0]               last;
  logic [N-1:0]               first;
  logic [N-1:0]               below;
  logic                       any_hit;
  tlb_pkg::entry_t            sel_entry;
  tlb_pkg::entry_t            front_entry;
  logic                       is_lookup;
  logic                       is_insert;
  logic                       is_delete;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= tlb_pkg::CfgW'(tlb_pkg::CfgReset);
    end else if (cfg_we) begin
      entries_in_use <= cfg_data;
    end
  end

  // Clamp the count to the range 1 .. built depth.
  assign cfg_ext = tlb_pkg::UseW'(entries_in_use);
  always_comb begin
    if (cfg_ext == '0) begin
      n_used = tlb_pkg::UseW'(1);
    end else if (cfg_ext > tlb_pkg::UseW'(N)) begin
      n_used = tlb_pkg::UseW'(N);
    end else begin
      n_used = cfg_ext;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tlb_pkg::ST_IDLE:   if (in_valid) state_next = tlb_pkg::ST_MATCH;
      tlb_pkg::ST_MATCH:  state_next = tlb_pkg::ST_UPDATE;
      tlb_pkg::ST_UPDATE: if (!out_valid || !out_stall) state_next = tlb_pkg::ST_IDLE;
      default:            state_next = tlb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    match_en = 1'b0;
    upd_go   = 1'b0;
    case (state)
      tlb_pkg::ST_IDLE:   in_stall = 1'b0;
      tlb_pkg::ST_MATCH:  match_en = 1'b1;
      tlb_pkg::ST_UPDATE: upd_go   = !out_valid || !out_stall;
      default:            in_stall = 1'b1;
    endcase
  end

  assign in_take = in_valid && !in_stall;

  // Capture the request item.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_q   <= tlb_pkg::req_t'(req_type);
      pid_q   <= pid;
      page_q  <= page;
      frame_q <= frame;
    end
  end

  // Register the per-cell compare, masked to the positions in use.
  always_ff @(posedge clk) begin
    if (match_en) begin
      match_q <= match_c & in_use;
    end
  end

  // Pick the lowest matching position.
  assign first   = match_q & (~match_q + N'(1));
  assign below   = first - N'(1);
  assign any_hit = |match_q;

  assign is_lookup = (req_q == tlb_pkg::REQ_LOOKUP);
  assign is_insert = (req_q == tlb_pkg::REQ_INSERT);
  assign is_delete = (req_q == tlb_pkg::REQ_DELETE);

  // Select the matched entry by its one-hot flag.
  always_comb begin
    sel_entry = '0;
    for (int k = 0; k < N; k++) begin
      sel_entry = sel_entry | (first[k] ? cell_entry[k] : '0);
    end
  end

  // Entry written at the front: the moved entry or the new one.
  always_comb begin
    if (is_insert) begin
      front_entry.valid = 1'b1;
      front_entry.pid   = pid_q;
      front_entry.page  = page_q;
      front_entry.frame = frame_q;
    end else begin
      front_entry       = sel_entry;
      front_entry.valid = 1'b1;
    end
  end

  // Chain of cells with their per-position control.
  for (genvar i = 0; i < N; i++) begin : g_cell
    tlb_pkg::entry_t prev_e;
    tlb_pkg::entry_t next_e;

    assign in_use[i] = tlb_pkg::UseW'(i) < n_used;
    assign last[i]   = tlb_pkg::UseW'(i + 1) == n_used;

    if (i == 0) begin : g_head
      assign prev_e = '0;
    end else begin : g_body
      assign prev_e = cell_entry[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cell_entry[i+1];
    end

    always_comb begin
      cell_op[i] = tlb_pkg::CELL_HOLD;
      if (upd_go) begin
        case (req_q)
          tlb_pkg::REQ_LOOKUP: begin
            if (any_hit) begin
              if (i == 0) begin
                cell_op[i] = tlb_pkg::CELL_LOAD;
              end else if (below[i] || first[i]) begin
                cell_op[i] = tlb_pkg::CELL_PREV;
              end
            end
          end
          tlb_pkg::REQ_INSERT: begin
            if (i == 0) begin
              cell_op[i] = tlb_pkg::CELL_LOAD;
            end else if (in_use[i]) begin
              cell_op[i] = tlb_pkg::CELL_PREV;
            end
          end
          tlb_pkg::REQ_DELETE: begin
            if (any_hit && in_use[i] && !below[i]) begin
              cell_op[i] = last[i] ? tlb_pkg::CELL_CLEAR : tlb_pkg::CELL_NEXT;
            end
          end
          tlb_pkg::REQ_FLUSH: cell_op[i] = tlb_pkg::CELL_CLEAR;
          default:            cell_op[i] = tlb_pkg::CELL_HOLD;
        endcase
      end
    end

    tlb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (cell_op[i]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .load_entry (front_entry),
      .req_pid    (pid_q),
      .req_page   (page_q),
      .entry      (cell_entry[i]),
      .match      (match_c[i])
    );
  end

  // Result valid: set on update, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (upd_go) begin
      hit       <= (is_lookup || is_delete) && any_hit;
      frame_out <= (is_lookup && any_hit) ? sel_entry.frame : '0;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the move-to-front TLB: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_top;

  localparam int IdleLimit = 2000;
  localparam int SettleCycles = 8;
  localparam int RandomItems = 750;
  localparam int KeyPoolSize = 12;

  typedef struct packed {
    logic                       hit;
    logic [tlb_pkg::FrameW-1:0] frame;
  } translation_t;

  // Clock and block ports; every input starts at a known value
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [tlb_pkg::ReqW-1:0]   req_type = '0;
  logic [tlb_pkg::PidW-1:0]   pid = '0;
  logic [tlb_pkg::PageW-1:0]  page = '0;
  logic [tlb_pkg::FrameW-1:0] frame = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       hit;
  logic [tlb_pkg::FrameW-1:0] frame_out;
  logic                       cfg_we = 1'b0;
  logic [tlb_pkg::CfgW-1:0]   cfg_data = '0;

  // Shadow copy of the TLB and its register
  tlb_pkg::entry_t          shadow_tlb [tlb_pkg::TlbDepth];
  logic [tlb_pkg::CfgW-1:0] shadow_in_use = tlb_pkg::CfgW'(tlb_pkg::CfgReset);
  translation_t             pending_translations[$];

  // Run statistics
  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int hits_seen = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  logic [tlb_pkg::PidW-1:0]  pool_pid  [KeyPoolSize];
  logic [tlb_pkg::PageW-1:0] pool_page [KeyPoolSize];

  tlb_lru_move_to_front dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .pid       (pid),
    .page      (page),
    .frame     (frame),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .frame_out (frame_out),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Work out the result of one request and advance the shadow TLB
  function automatic translation_t predict_translation(tlb_pkg::req_t r,
                                                       logic [tlb_pkg::PidW-1:0] p,
                                                       logic [tlb_pkg::PageW-1:0] pg,
                                                       logic [tlb_pkg::FrameW-1:0] fr);
    int n;
    int pos;
    tlb_pkg::entry_t found;
    translation_t res;
    n = (shadow_in_use == 0) ? 1 :
        (shadow_in_use > tlb_pkg::TlbDepth) ? tlb_pkg::TlbDepth : int'(shadow_in_use);
    res = '0;
    pos = n;
    for (int i = n - 1; i >= 0; i--) begin
      if (shadow_tlb[i].valid && shadow_tlb[i].pid == p && shadow_tlb[i].page == pg) begin
        pos = i;
      end
    end
    case (r)
      tlb_pkg::REQ_LOOKUP: begin
        if (pos < n) begin
          found = shadow_tlb[pos];
          for (int i = pos; i > 0; i--) shadow_tlb[i] = shadow_tlb[i-1];
          shadow_tlb[0] = found;
          res.hit = 1'b1;
          res.frame = found.frame;
        end
      end
      tlb_pkg::REQ_INSERT: begin
        for (int i = n - 1; i > 0; i--) shadow_tlb[i] = shadow_tlb[i-1];
        shadow_tlb[0] = '{valid: 1'b1, pid: p, page: pg, frame: fr};
      end
      tlb_pkg::REQ_DELETE: begin
        if (pos < n) begin
          for (int i = pos; i + 1 < n; i++) shadow_tlb[i] = shadow_tlb[i+1];
          shadow_tlb[n-1].valid = 1'b0;
          res.hit = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < tlb_pkg::TlbDepth; i++) shadow_tlb[i].valid = 1'b0;
      end
    endcase
    return res;
  endfunction

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // Send one item; returns just after the edge that accepted it
  task automatic send_request(tlb_pkg::req_t r, logic [tlb_pkg::PidW-1:0] p,
                              logic [tlb_pkg::PageW-1:0] pg,
                              logic [tlb_pkg::FrameW-1:0] fr);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    pid <= p;
    page <= pg;
    frame <= fr;
    do @(posedge clk); while (in_stall);
    pending_translations.push_back(predict_translation(r, p, pg, fr));
    requests_sent++;
  endtask

  // Drain the block, then write the register while it is idle
  task automatic set_entries_in_use(logic [tlb_pkg::CfgW-1:0] value);
    in_valid <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_in_use = value;
    settings_used++;
  endtask

  // Check each result against the oldest expectation; draw the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (pending_translations.size() == 0) begin
        $error("result with nothing expected: hit=%0b frame_out=%0h", hit, frame_out);
        mismatches++;
      end else begin
        if (hit !== pending_translations[0].hit) begin
          $error("hit: expected %0b, got %0b", pending_translations[0].hit, hit);
          mismatches++;
        end
        if (frame_out !== pending_translations[0].frame) begin
          $error("frame_out: expected %0h, got %0h", pending_translations[0].frame, frame_out);
          mismatches++;
        end
        if (pending_translations[0].hit) hits_seen++;
        void'(pending_translations.pop_front());
      end
      stall_left = draw_gap(recv_quiet);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Empty table, field extremes, partial matches, duplicates, delete miss and flush
  task automatic test_basic_requests();
    send_request(tlb_pkg::REQ_LOOKUP, 16'h0000, 12'h000, 12'hfff);
    send_request(tlb_pkg::REQ_INSERT, 16'h0000, 12'h000, 12'h000);
    send_request(tlb_pkg::REQ_INSERT, 16'hffff, 12'hfff, 12'hfff);
    send_request(tlb_pkg::REQ_LOOKUP, 16'h0000, 12'h000, 12'h5a5);
    send_request(tlb_pkg::REQ_LOOKUP, 16'hffff, 12'hfff, 12'h000);
    send_request(tlb_pkg::REQ_LOOKUP, 16'hffff, 12'h000, 12'h000);
    send_request(tlb_pkg::REQ_LOOKUP, 16'h0000, 12'hfff, 12'h000);
    // A second copy of the same key shadows the older one
    send_request(tlb_pkg::REQ_INSERT, 16'hffff, 12'hfff, 12'h123);
    send_request(tlb_pkg::REQ_LOOKUP, 16'hffff, 12'hfff, 12'h000);
    send_request(tlb_pkg::REQ_DELETE, 16'hffff, 12'hfff, 12'hfff);
    send_request(tlb_pkg::REQ_LOOKUP, 16'hffff, 12'hfff, 12'h000);
    send_request(tlb_pkg::REQ_DELETE, 16'h1234, 12'h555, 12'h000);
    send_request(tlb_pkg::REQ_FLUSH, 16'hffff, 12'hfff, 12'hfff);
    send_request(tlb_pkg::REQ_LOOKUP, 16'h0000, 12'h000, 12'h000);
  endtask

  // Narrow counts: eviction at the last position, zero and over-range counts
  task automatic test_entry_counts();
    set_entries_in_use(5'd2);
    send_request(tlb_pkg::REQ_INSERT, 16'h0001, 12'h001, 12'h001);
    send_request(tlb_pkg::REQ_INSERT, 16'h0002, 12'h002, 12'h002);
    send_request(tlb_pkg::REQ_INSERT, 16'h0003, 12'h003, 12'h003);
    send_request(tlb_pkg::REQ_LOOKUP, 16'h0001, 12'h001, 12'h000);
    send_request(tlb_pkg::REQ_LOOKUP, 16'h0002, 12'h002, 12'h000);
    set_entries_in_use(5'd0);
    send_request(tlb_pkg::REQ_INSERT, 16'h0004, 12'h004, 12'h004);
    send_request(tlb_pkg::REQ_LOOKUP, 16'h0003, 12'h003, 12'h000);
    set_entries_in_use(5'd31);
    // Entries beyond the narrow count kept their contents
    send_request(tlb_pkg::REQ_LOOKUP, 16'h0003, 12'h003, 12'h000);
    send_request(tlb_pkg::REQ_DELETE, 16'h0004, 12'h004, 12'h000);
  endtask

  // Random traffic over a small key pool so that lookups and deletes often hit
  task automatic test_random_traffic();
    logic [tlb_pkg::CfgW-1:0] counts [9];
    logic [tlb_pkg::PidW-1:0] base_pid [3];
    logic [tlb_pkg::PidW-1:0] p;
    logic [tlb_pkg::PageW-1:0] pg;
    int per_phase;
    int kind;
    int k;
    tlb_pkg::req_t r;
    counts = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd9, 5'd2, 5'd17, 5'd16};
    counts[8] = tlb_pkg::CfgW'($urandom_range(0, 31));
    per_phase = RandomItems / 9;
    for (int i = 0; i < 3; i++) base_pid[i] = tlb_pkg::PidW'($urandom);
    for (int i = 0; i < KeyPoolSize; i++) begin
      pool_pid[i] = base_pid[i % 3];
      pool_page[i] = tlb_pkg::PageW'($urandom);
    end
    for (int ph = 0; ph < 9; ph++) begin
      set_entries_in_use(counts[ph]);
      for (int j = 0; j < per_phase; j++) begin
        // Switch between idling and back-to-back stretches
        if (j % 40 == 0) begin
          send_quiet = ($urandom_range(0, 2) == 0);
          recv_quiet = ($urandom_range(0, 2) == 0);
        end
        kind = $urandom_range(0, 99);
        r = (kind < 45) ? tlb_pkg::REQ_LOOKUP : (kind < 75) ? tlb_pkg::REQ_INSERT :
            (kind < 96) ? tlb_pkg::REQ_DELETE : tlb_pkg::REQ_FLUSH;
        if ($urandom_range(0, 9) < 8) begin
          k = $urandom_range(0, KeyPoolSize - 1);
          p = pool_pid[k];
          pg = pool_page[k];
        end else begin
          p = tlb_pkg::PidW'($urandom);
          pg = tlb_pkg::PageW'($urandom);
        end
        send_request(r, p, pg, tlb_pkg::FrameW'($urandom));
      end
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < tlb_pkg::TlbDepth; i++) shadow_tlb[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_requests();
    test_entry_counts();
    test_random_traffic();
    // Drain and let the pipeline settle before judging
    in_valid <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    $display("Sent %0d requests across %0d entries_in_use settings after reset",
             requests_sent, settings_used);
    $display("Checked %0d results, %0d of them hits", results_checked, hits_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== tlb_lru_move_to_front.f =====
sv/tlb_pkg.sv
sv/tlb_cell.sv
sv/tlb_lru_move_to_front.sv
tb/sv/tb_top.sv
